// ----- hdl/jsu_pkg.sv -----
package jsu_pkg;

   // One input item: a raw byte of the literal, or the end of input.
   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_item_type;

   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [20:0] REPL_CP = 21'h00FFFD;

   // Decoder phase of the front end.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_TEXT,
      PH_ESC,
      PH_CONTCR,
      PH_CONTLF,
      PH_X1,
      PH_X2,
      PH_USTART,
      PH_U4,
      PH_UBRACE
   } phase_type;

   // What closes a command: nothing, a string-complete item or an error item.
   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_DONE,
      FIN_ERROR
   } fin_type;

   // An element is either a raw byte passed through as is, or a code point
   // that the back end encodes as UTF-8.
   typedef struct packed {
      logic        is_raw;
      logic [20:0] value;
   } elem_type;

   // Everything one input item asks the back end to emit, in order:
   // up to two elements, then the closing item if any.
   typedef struct packed {
      logic [1:0] n_elem;
      fin_type    fin;
      elem_type   e0;
      elem_type   e1;
   } cmd_type;

endpackage

// ----- hdl/jsu_front.sv -----
module jsu_front
   import jsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_stall,
   input  logic         csr_valid,
   input  logic         csr_data,
   input  logic         queue_full,
   output logic         push_valid,
   output cmd_type      push_cmd
);

   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_ESC_B   = 8'h62;
   localparam logic [7:0] CH_ESC_F   = 8'h66;
   localparam logic [7:0] CH_ESC_N   = 8'h6E;
   localparam logic [7:0] CH_ESC_R   = 8'h72;
   localparam logic [7:0] CH_ESC_T   = 8'h74;
   localparam logic [7:0] CH_ESC_U   = 8'h75;
   localparam logic [7:0] CH_ESC_V   = 8'h76;
   localparam logic [7:0] CH_ESC_X   = 8'h78;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_FF    = 8'h0C;
   localparam logic [7:0] BYTE_HT    = 8'h09;
   localparam logic [7:0] BYTE_VT    = 8'h0B;
   localparam logic [4:0] HEX_NONE   = 5'd16;

   localparam cmd_type CMD_EMPTY = '{n_elem: 2'd0, fin: FIN_NONE, e0: '0, e1: '0};

   typedef struct packed {
      cmd_type    cmd;
      logic       lead_v;
      logic [9:0] lead;
   } take_type;

   function automatic logic [4:0] hexval(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 5'(c - CH_UPPER_A) + 5'd10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 5'(c - CH_LOWER_A) + 5'd10;
      return HEX_NONE;
   endfunction

   function automatic cmd_type cmd_add(input cmd_type c, input logic raw,
                                       input logic [20:0] v);
      cmd_type r;
      r = c;
      if (c.n_elem == 2'd0) begin
         r.e0     = '{is_raw: raw, value: v};
         r.n_elem = 2'd1;
      end else begin
         r.e1     = '{is_raw: raw, value: v};
         r.n_elem = 2'd2;
      end
      return r;
   endfunction

   // Values past the last plane or inside the surrogate range encode as U+FFFD.
   function automatic logic [20:0] fix_cp(input logic [31:0] v);
      if (v > 32'h0010FFFF || (v >= 32'h0000D800 && v <= 32'h0000DFFF)) return REPL_CP;
      return v[20:0];
   endfunction

   // Hands one decoded escape value to the surrogate pairing logic.
   function automatic take_type take_code(input cmd_type c, input logic lv,
                                          input logic [9:0] ld, input logic [31:0] v);
      take_type    r;
      logic [20:0] j;
      r.cmd    = c;
      r.lead_v = lv;
      r.lead   = ld;
      j = 21'({ld, v[9:0]}) + 21'h010000;
      if (v >= 32'h0000D800 && v <= 32'h0000DBFF) begin
         if (lv) r.cmd = cmd_add(r.cmd, 1'b0, REPL_CP);
         r.lead_v = 1'b1;
         r.lead   = v[9:0];
      end else if (v >= 32'h0000DC00 && v <= 32'h0000DFFF) begin
         if (!lv) begin
            r.cmd = cmd_add(r.cmd, 1'b0, REPL_CP);
         end else begin
            if (j[15:1] == 15'h7FFF) begin
               r.cmd = cmd_add(r.cmd, 1'b0, REPL_CP);
               r.cmd = cmd_add(r.cmd, 1'b0, REPL_CP);
            end else begin
               r.cmd = cmd_add(r.cmd, 1'b0, j);
            end
            r.lead_v = 1'b0;
         end
      end else begin
         if (lv) r.cmd = cmd_add(r.cmd, 1'b0, REPL_CP);
         r.lead_v = 1'b0;
         r.cmd    = cmd_add(r.cmd, 1'b0, fix_cp(v));
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic        quote_ff, quote_in;
   logic        lead_v_ff, lead_v_in;
   logic [9:0]  lead_ff, lead_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        strict_ff;

   logic        accept;
   cmd_type     cmd;
   logic        err;
   logic        do_text;
   logic [7:0]  b;
   logic [4:0]  d;
   logic [31:0] acc_sh;
   logic [7:0]  q;
   take_type    tc;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !req_stall;
   assign push_valid = accept && (cmd.n_elem != 2'd0 || cmd.fin != FIN_NONE);
   assign push_cmd   = cmd;

   always_comb begin
      phase_in  = phase_ff;
      quote_in  = quote_ff;
      lead_v_in = lead_v_ff;
      lead_in   = lead_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      cmd       = CMD_EMPTY;
      err       = 1'b0;
      do_text   = 1'b0;
      b         = req_item.data_byte;
      d         = hexval(b);
      acc_sh    = {acc_ff[27:0], d[3:0]};
      q         = quote_ff ? CH_SQUOTE : CH_DQUOTE;
      tc        = '0;

      if (req_item.req_type == REQ_END) begin
         case (phase_ff)
            PH_TEXT, PH_ESC, PH_CONTCR, PH_CONTLF, PH_UBRACE: begin
               if (strict_ff) begin
                  err = 1'b1;
               end else begin
                  if (phase_ff == PH_UBRACE) begin
                     tc        = take_code(cmd, lead_v_in, lead_in, acc_ff);
                     cmd       = tc.cmd;
                     lead_v_in = tc.lead_v;
                     lead_in   = tc.lead;
                  end
                  if (lead_v_in) cmd = cmd_add(cmd, 1'b0, REPL_CP);
                  cmd.fin   = FIN_DONE;
                  phase_in  = PH_IDLE;
                  lead_v_in = 1'b0;
                  acc_in    = '0;
                  cnt_in    = '0;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (b == CH_DQUOTE) begin
                  quote_in = 1'b0;
                  phase_in = PH_TEXT;
               end else if (b == CH_SQUOTE && !strict_ff) begin
                  quote_in = 1'b1;
                  phase_in = PH_TEXT;
               end else begin
                  err = 1'b1;
               end
               lead_v_in = 1'b0;
               acc_in    = '0;
               cnt_in    = '0;
            end
            PH_TEXT: begin
               do_text = 1'b1;
            end
            PH_CONTCR: begin
               phase_in = PH_TEXT;
               do_text  = (b != CH_NL);
            end
            PH_CONTLF: begin
               phase_in = PH_TEXT;
               do_text  = (b != CH_CR);
            end
            PH_ESC: begin
               if (b != CH_ESC_U && lead_v_in) begin
                  cmd       = cmd_add(cmd, 1'b0, REPL_CP);
                  lead_v_in = 1'b0;
               end
               phase_in = PH_TEXT;
               case (b)
                  CH_CR: begin
                     if (strict_ff) err = 1'b1;
                     else phase_in = PH_CONTCR;
                  end
                  CH_NL: begin
                     if (strict_ff) err = 1'b1;
                     else phase_in = PH_CONTLF;
                  end
                  CH_ESC_B: cmd = cmd_add(cmd, 1'b1, 21'(BYTE_BS));
                  CH_ESC_F: cmd = cmd_add(cmd, 1'b1, 21'(BYTE_FF));
                  CH_ESC_N: cmd = cmd_add(cmd, 1'b1, 21'(CH_NL));
                  CH_ESC_R: cmd = cmd_add(cmd, 1'b1, 21'(CH_CR));
                  CH_ESC_T: cmd = cmd_add(cmd, 1'b1, 21'(BYTE_HT));
                  CH_ESC_V: begin
                     if (strict_ff) err = 1'b1;
                     else cmd = cmd_add(cmd, 1'b1, 21'(BYTE_VT));
                  end
                  CH_ESC_X: begin
                     if (strict_ff) begin
                        err = 1'b1;
                     end else begin
                        phase_in = PH_X1;
                        acc_in   = '0;
                     end
                  end
                  CH_ESC_U: begin
                     phase_in = PH_USTART;
                     acc_in   = '0;
                     cnt_in   = '0;
                  end
                  CH_DQUOTE, CH_BSLASH, CH_SLASH: cmd = cmd_add(cmd, 1'b1, 21'(b));
                  default: begin
                     if (strict_ff) err = 1'b1;
                     else cmd = cmd_add(cmd, 1'b1, 21'(b));
                  end
               endcase
            end
            PH_X1: begin
               if (d == HEX_NONE) begin
                  err = 1'b1;
               end else begin
                  acc_in   = 32'(d[3:0]);
                  phase_in = PH_X2;
               end
            end
            PH_X2: begin
               if (d == HEX_NONE) begin
                  err = 1'b1;
               end else begin
                  cmd      = cmd_add(cmd, 1'b1, 21'({acc_ff[3:0], d[3:0]}));
                  acc_in   = '0;
                  phase_in = PH_TEXT;
               end
            end
            PH_USTART: begin
               if (b == CH_LBRACE) begin
                  phase_in = PH_UBRACE;
                  acc_in   = '0;
               end else if (d == HEX_NONE) begin
                  err = 1'b1;
               end else begin
                  acc_in   = 32'(d[3:0]);
                  cnt_in   = 2'd1;
                  phase_in = PH_U4;
               end
            end
            PH_U4: begin
               if (d == HEX_NONE) begin
                  err = 1'b1;
               end else if (cnt_ff == 2'd3) begin
                  // Fourth digit: the value is complete.
                  tc        = take_code(cmd, lead_v_in, lead_in, acc_sh);
                  cmd       = tc.cmd;
                  lead_v_in = tc.lead_v;
                  lead_in   = tc.lead;
                  phase_in  = PH_TEXT;
                  acc_in    = '0;
                  cnt_in    = '0;
               end else begin
                  acc_in = acc_sh;
                  cnt_in = cnt_ff + 2'd1;
               end
            end
            PH_UBRACE: begin
               if (b == CH_RBRACE) begin
                  tc        = take_code(cmd, lead_v_in, lead_in, acc_ff);
                  cmd       = tc.cmd;
                  lead_v_in = tc.lead_v;
                  lead_in   = tc.lead;
                  phase_in  = PH_TEXT;
                  acc_in    = '0;
               end else if (d == HEX_NONE || acc_ff[31:28] != 4'd0) begin
                  // Another digit would push the value past 32 bits.
                  err = 1'b1;
               end else begin
                  acc_in = acc_sh;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase

         if (do_text) begin
            if (b == q) begin
               if (lead_v_in) cmd = cmd_add(cmd, 1'b0, REPL_CP);
               cmd.fin   = FIN_DONE;
               phase_in  = PH_IDLE;
               lead_v_in = 1'b0;
               acc_in    = '0;
               cnt_in    = '0;
            end else if (b == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else if (strict_ff && b < CH_SPACE) begin
               err = 1'b1;
            end else begin
               if (lead_v_in) cmd = cmd_add(cmd, 1'b0, REPL_CP);
               lead_v_in = 1'b0;
               cmd       = cmd_add(cmd, 1'b1, 21'(b));
            end
         end
      end

      // An error drops whatever this item would have produced.
      if (err) begin
         cmd       = CMD_EMPTY;
         cmd.fin   = FIN_ERROR;
         phase_in  = PH_IDLE;
         lead_v_in = 1'b0;
         acc_in    = '0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         quote_ff  <= 1'b0;
         lead_v_ff <= 1'b0;
         lead_ff   <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         quote_ff  <= quote_in;
         lead_v_ff <= lead_v_in;
         lead_ff   <= lead_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_valid) begin
         strict_ff <= csr_data;
      end
   end

endmodule

// ----- hdl/jsu_queue.sv -----
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push_valid) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/jsu_back.sv -----
module jsu_back
   import jsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // Number of bytes of an element, minus one.
   function automatic logic [1:0] elem_len_m1(input elem_type e);
      if (e.is_raw || e.value < 21'h000080) return 2'd0;
      if (e.value < 21'h000800) return 2'd1;
      if (e.value < 21'h010000) return 2'd2;
      return 2'd3;
   endfunction

   function automatic logic [7:0] elem_byte(input elem_type e, input logic [1:0] k);
      logic [20:0] cp;
      cp = e.value;
      case (elem_len_m1(e))
         2'd0: return cp[7:0];
         2'd1: return (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         2'd2: begin
            case (k)
               2'd0:    return {4'b1110, cp[15:12]};
               2'd1:    return {2'b10, cp[11:6]};
               default: return {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (k)
               2'd0:    return {5'b11110, cp[20:18]};
               2'd1:    return {2'b10, cp[17:12]};
               2'd2:    return {2'b10, cp[11:6]};
               default: return {2'b10, cp[5:0]};
            endcase
         end
      endcase
   endfunction

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         at_fin_ff, at_fin_in;
   logic         elem_idx_ff, elem_idx_in;
   logic [1:0]   byte_idx_ff, byte_idx_in;

   logic         advance;
   logic         at_fin;
   elem_type     elem;
   logic [1:0]   len_m1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      advance      = head_valid && (!rsp_valid_ff || !rsp_stall);
      at_fin       = at_fin_ff || (head_data.n_elem == 2'd0);
      elem         = elem_idx_ff ? head_data.e1 : head_data.e0;
      len_m1       = elem_len_m1(elem);
      pop          = 1'b0;
      at_fin_in    = at_fin_ff;
      elem_idx_in  = elem_idx_ff;
      byte_idx_in  = byte_idx_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

      if (advance) begin
         if (at_fin) begin
            rsp_item_in.result_kind = (head_data.fin == FIN_ERROR) ? KIND_ERROR : KIND_DONE;
            rsp_item_in.out_byte    = 8'd0;
            rsp_item_in.last_of_run = 1'b1;
            pop = 1'b1;
         end else begin
            rsp_item_in.result_kind = KIND_BYTE;
            rsp_item_in.out_byte    = elem_byte(elem, byte_idx_ff);
            rsp_item_in.last_of_run = 1'b0;
            if (byte_idx_ff == len_m1) begin
               if (!elem_idx_ff && head_data.n_elem == 2'd2) begin
                  elem_idx_in = 1'b1;
                  byte_idx_in = 2'd0;
               end else if (head_data.fin != FIN_NONE) begin
                  at_fin_in   = 1'b1;
                  byte_idx_in = 2'd0;
               end else begin
                  rsp_item_in.last_of_run = 1'b1;
                  pop = 1'b1;
               end
            end else begin
               byte_idx_in = byte_idx_ff + 2'd1;
            end
         end
         if (pop) begin
            at_fin_in   = 1'b0;
            elem_idx_in = 1'b0;
            byte_idx_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         at_fin_ff    <= 1'b0;
         elem_idx_ff  <= 1'b0;
         byte_idx_ff  <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         at_fin_ff    <= at_fin_in;
         elem_idx_ff  <= elem_idx_in;
         byte_idx_ff  <= byte_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// ----- hdl/json_string_unescape_utf8_core.sv -----
// Streaming unescaper for one quoted string literal: feed the raw bytes of the
// literal, opening quote first, and the block returns the unescaped content as
// UTF-8 bytes, then a string-complete item, or a single error item. JSON escapes,
// \uXXXX and \u{...} are decoded and surrogate pairs are joined; with the
// strict_mode register cleared, single quotes, \v, \xHH, unknown escapes, raw
// control bytes and backslash line continuation are accepted too. The last_of_run
// bit is set on the final result caused by one input item. The front end takes
// one input item per cycle unless the queue is full, decodes it and queues a
// short command; the back end sequencer emits one result item per cycle while
// the receiver does not stall. One input item can yield up to eight results,
// e.g. a replaced lead surrogate, a four byte character and the string-complete
// item when the input ends inside an unclosed \u{...} escape. The queue of
// QUEUE_DEPTH commands between the two lets the input keep flowing while
// multi-byte output drains.
module json_string_unescape_utf8_core
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic    queue_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_data;

   // The mode register is a single flip-flop and takes any write at once.
   assign csr_ready = 1'b1;

   // The front end decodes input items into commands of up to two elements.
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // Commands wait here so that input and output stall independently.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // The back end turns the head command into result items, one per cycle while
   // the receiver does not stall, through a registered output stage.
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

// ----- test/unescape_checker.sv -----
`timescale 1ns / 1ps

module unescape_checker
   import jsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_data,
   output int           fail_count,
   output int           pending
);

   localparam logic [7:0] DQUOTE    = 8'h22;
   localparam logic [7:0] SQUOTE    = 8'h27;
   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam int         MAX_RUN   = 8;

   // Predicted decoder state.
   logic        strict;
   phase_type   phase;
   logic        single_quoted;
   logic [10:0] lead;      // bit 10 flags a pending lead surrogate
   logic [31:0] acc;
   logic [3:0]  ndigits;

   rsp_item_type run_out[$];        // results of the item being decoded
   rsp_item_type utf8_expected[$];  // predicted results not yet seen

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] result mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void emit(input logic [1:0] kind, input logic [7:0] b);
      rsp_item_type r;
      r.result_kind = kind;
      r.out_byte    = b;
      r.last_of_run = 1'b0;
      if (run_out.size() < MAX_RUN) run_out = {run_out, r};
   endfunction

   function automatic void back_to_idle();
      phase   = PH_IDLE;
      lead    = '0;
      acc     = '0;
      ndigits = '0;
   endfunction

   // An error drops whatever this item produced so far.
   function automatic void raise_error();
      run_out.delete();
      emit(KIND_ERROR, 8'h00);
      back_to_idle();
   endfunction

   function automatic logic [4:0] hex_value(input logic [7:0] b);
      if (b >= "0" && b <= "9") return 5'(b - 8'h30);
      if (b >= "A" && b <= "F") return 5'(b - 8'h41 + 8'd10);
      if (b >= "a" && b <= "f") return 5'(b - 8'h61 + 8'd10);
      return 5'd16;
   endfunction

   function automatic void put_utf8(input logic [31:0] cp_in);
      logic [31:0] cp;
      cp = cp_in;
      if (cp < 32'h80) begin
         emit(KIND_BYTE, cp[7:0]);
      end else if (cp < 32'h800) begin
         emit(KIND_BYTE, 8'hC0 | {3'b0, cp[10:6]});
         emit(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]});
      end else begin
         if ((cp >= 32'hD800 && cp <= 32'hDFFF) || cp > 32'h10_FFFF) cp = {11'd0, REPL_CP};
         if (cp < 32'h1_0000) begin
            emit(KIND_BYTE, 8'hE0 | {4'b0, cp[15:12]});
            emit(KIND_BYTE, 8'h80 | {2'b0, cp[11:6]});
            emit(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]});
         end else begin
            emit(KIND_BYTE, 8'hF0 | {5'b0, cp[20:18]});
            emit(KIND_BYTE, 8'h80 | {2'b0, cp[17:12]});
            emit(KIND_BYTE, 8'h80 | {2'b0, cp[11:6]});
            emit(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]});
         end
      end
   endfunction

   function automatic logic is_nonchar(input logic [31:0] cp);
      if (cp >= 32'hFDD0 && cp <= 32'hFDEF) return 1'b1;
      return cp <= 32'h10_FFFF && (cp & 32'hFFFE) == 32'hFFFE;
   endfunction

   function automatic void drop_lead();
      if (lead[10]) begin
         put_utf8({11'd0, REPL_CP});
         lead = '0;
      end
   endfunction

   function automatic void take_code(input logic [31:0] v);
      logic [31:0] joined;
      if (v >= 32'hD800 && v <= 32'hDBFF) begin
         if (lead[10]) put_utf8({11'd0, REPL_CP});
         lead = {1'b1, v[9:0]};
      end else if (v >= 32'hDC00 && v <= 32'hDFFF) begin
         if (!lead[10]) begin
            put_utf8({11'd0, REPL_CP});
         end else begin
            joined = {22'd0, lead[9:0]} * 32'h400 + (v - 32'hDC00) + 32'h1_0000;
            if (is_nonchar(joined)) begin
               put_utf8({11'd0, REPL_CP});
               put_utf8({11'd0, REPL_CP});
            end else begin
               put_utf8(joined);
            end
            lead = '0;
         end
      end else begin
         drop_lead();
         put_utf8(v);
      end
   endfunction

   function automatic void text_byte(input logic [7:0] b);
      logic [7:0] q;
      q = single_quoted ? SQUOTE : DQUOTE;
      if (b == q) begin
         drop_lead();
         emit(KIND_DONE, 8'h00);
         back_to_idle();
      end else if (b == BACKSLASH) begin
         phase = PH_ESC;
      end else if (strict && b < 8'h20) begin
         raise_error();
      end else begin
         drop_lead();
         emit(KIND_BYTE, b);
      end
   endfunction

   function automatic void escape_byte(input logic [7:0] b);
      if (b != "u") drop_lead();
      phase = PH_TEXT;
      case (b)
         8'h0D: if (strict) raise_error(); else phase = PH_CONTCR;
         8'h0A: if (strict) raise_error(); else phase = PH_CONTLF;
         "b": emit(KIND_BYTE, 8'h08);
         "f": emit(KIND_BYTE, 8'h0C);
         "n": emit(KIND_BYTE, 8'h0A);
         "r": emit(KIND_BYTE, 8'h0D);
         "t": emit(KIND_BYTE, 8'h09);
         "v": if (strict) raise_error(); else emit(KIND_BYTE, 8'h0B);
         "x": begin
            if (strict) begin
               raise_error();
            end else begin
               phase = PH_X1;
               acc   = '0;
            end
         end
         "u": begin
            phase   = PH_USTART;
            acc     = '0;
            ndigits = '0;
         end
         DQUOTE, BACKSLASH, 8'h2F: emit(KIND_BYTE, b);
         default: if (strict) raise_error(); else emit(KIND_BYTE, b);
      endcase
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [4:0] d;
      d = hex_value(b);
      case (phase)
         PH_IDLE: begin
            if (b == DQUOTE) begin
               back_to_idle();
               single_quoted = 1'b0;
               phase = PH_TEXT;
            end else if (b == SQUOTE && !strict) begin
               back_to_idle();
               single_quoted = 1'b1;
               phase = PH_TEXT;
            end else begin
               raise_error();
            end
         end
         PH_TEXT: text_byte(b);
         PH_ESC: escape_byte(b);
         PH_CONTCR: begin
            phase = PH_TEXT;
            if (b != 8'h0A) text_byte(b);
         end
         PH_CONTLF: begin
            phase = PH_TEXT;
            if (b != 8'h0D) text_byte(b);
         end
         PH_X1: begin
            if (d > 5'd15) begin
               raise_error();
            end else begin
               acc   = {27'd0, d};
               phase = PH_X2;
            end
         end
         PH_X2: begin
            if (d > 5'd15) begin
               raise_error();
            end else begin
               emit(KIND_BYTE, {acc[3:0], d[3:0]});
               acc   = '0;
               phase = PH_TEXT;
            end
         end
         PH_USTART: begin
            if (b == "{") begin
               phase = PH_UBRACE;
               acc   = '0;
            end else if (d > 5'd15) begin
               raise_error();
            end else begin
               acc     = {27'd0, d};
               ndigits = 4'd1;
               phase   = PH_U4;
            end
         end
         PH_U4: begin
            if (d > 5'd15) begin
               raise_error();
            end else begin
               acc     = {acc[27:0], d[3:0]};
               ndigits = ndigits + 4'd1;
               if (ndigits >= 4'd4) begin
                  phase = PH_TEXT;
                  take_code(acc);
                  acc     = '0;
                  ndigits = '0;
               end
            end
         end
         PH_UBRACE: begin
            if (b == "}") begin
               phase = PH_TEXT;
               take_code(acc);
               acc = '0;
            end else if (d > 5'd15 || acc > 32'h0FFF_FFFF) begin
               raise_error();
            end else begin
               acc = {acc[27:0], d[3:0]};
            end
         end
         default: raise_error();
      endcase
   endfunction

   function automatic void decode_end();
      if (phase == PH_TEXT || phase == PH_ESC || phase == PH_CONTCR ||
          phase == PH_CONTLF || phase == PH_UBRACE) begin
         if (strict) begin
            raise_error();
         end else begin
            if (phase == PH_UBRACE) take_code(acc);
            drop_lead();
            emit(KIND_DONE, 8'h00);
            back_to_idle();
         end
      end else begin
         raise_error();
      end
   endfunction

   function automatic void predict_item(input req_item_type it);
      rsp_item_type r;
      run_out.delete();
      if (it.req_type == REQ_END) decode_end();
      else decode_byte(it.data_byte);
      if (run_out.size() > 0) begin
         r = run_out.pop_back();
         r.last_of_run = 1'b1;
         run_out = {run_out, r};
      end
      utf8_expected = {utf8_expected, run_out};
   endfunction

   always @(posedge clock) begin
      rsp_item_type seen, want;
      if (reset) begin
         strict        = 1'b1;
         single_quoted = 1'b0;
         back_to_idle();
         utf8_expected.delete();
      end else begin
         if (csr_valid && csr_ready) strict = csr_data;
         if (req_valid && !req_stall) predict_item(req_item);
         if (rsp_valid && !rsp_stall) begin
            seen = rsp_item;
            if (utf8_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0d",
                                         seen.result_kind, seen.out_byte, seen.last_of_run));
            end else begin
               want = utf8_expected.pop_front();
               if (seen.result_kind !== want.result_kind)
                  report_mismatch($sformatf("result_kind %0d, predicted %0d",
                                            seen.result_kind, want.result_kind));
               if (seen.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                            seen.out_byte, want.out_byte));
               if (seen.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %0d, predicted %0d",
                                            seen.last_of_run, want.last_of_run));
            end
         end
      end
      pending <= utf8_expected.size();
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import jsu_pkg::*;

   localparam logic [7:0] DQUOTE    = 8'h22;
   localparam logic [7:0] SQUOTE    = 8'h27;
   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam int         RANDOM_ITEMS = 350;
   localparam int         SQUEEZE_CYCLES = 80;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b1;
   int           fail_count;
   int           pending;

   // Random idling on both channels is allowed while this is set.
   bit         gaps_on = 1'b1;
   // The strict_mode value last written to the block.
   logic       mode = 1'b1;
   int         sent = 0;
   // The stimulus asks for a long receiver hold-off by bumping squeeze_asks;
   // the receiver process serves each request once.
   int         squeeze_asks = 0;
   int         squeeze_done = 0;
   // Raw bytes of the literal being built, sent in order.
   logic [7:0] text_q[$];
   string      simple_escapes = "bfnrt\"\\/v'q";

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   json_string_unescape_utf8_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   unescape_checker mon (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Appends one byte to the literal being built.
   function automatic void add_byte(input logic [7:0] c);
      text_q = {text_q, c};
   endfunction

   // Offers one item and returns at the edge where it is taken. A short random
   // gap may come first; valid is otherwise left high so that back-to-back
   // items flow without a bubble.
   task automatic send_item(input logic kind, input logic [7:0] b);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{req_type: kind, data_byte: b};
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_item(REQ_DATA, text_q[i]);
      text_q.delete();
   endtask

   // Changes strict_mode. An end-of-input item goes first so the decoder is
   // back in its idle phase whatever the last literal left open. Then every
   // predicted result must have drained, and the bench waits once more before
   // the write.
   task automatic write_mode(input logic m);
      send_item(REQ_END, 8'($urandom_range(0, 255)));
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode = m;
   endtask

   task automatic queue_str(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Hex digits come in either letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'd0, n};
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
   endfunction

   task automatic queue_hex(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) add_byte(hex_char(v[4*i +: 4]));
   endtask

   // A 16-bit escape value, weighted toward the ranges where the encoder
   // changes behavior: one, two and three byte forms, both surrogate halves,
   // and the noncharacters.
   function automatic logic [15:0] pick_u16();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 16'h7F));
         1: return 16'($urandom_range(16'h80, 16'h7FF));
         2: return 16'($urandom_range(16'hD800, 16'hDBFF));
         3: return 16'($urandom_range(16'hDC00, 16'hDFFF));
         4: return 16'hFFFE + 16'($urandom_range(0, 1));
         5: return 16'hFDD0 + 16'($urandom_range(0, 31));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Appends one piece of string content. Most pieces are well formed so the
   // decoder gets deep into its escape handling; a share are raw noise and
   // broken escapes.
   task automatic queue_token();
      int          pick;
      logic [7:0]  c;
      logic [15:0] hi, lo;
      logic [31:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         c = 8'($urandom_range(8'h20, 8'h7E));
         if (c == DQUOTE || c == SQUOTE || c == BACKSLASH) c = "z";
         add_byte(c);
      end else if (pick < 30) begin
         add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 38) begin
         add_byte(8'($urandom_range(8'h80, 8'hFF)));
      end else if (pick < 42) begin
         // Control bytes pass in lax mode and fail in strict mode.
         add_byte(8'($urandom_range(0, 8'h1F)));
      end else if (pick < 52) begin
         add_byte(BACKSLASH);
         add_byte(simple_escapes[$urandom_range(0, simple_escapes.len() - 1)]);
      end else if (pick < 65) begin
         queue_str("\\u");
         queue_hex({16'd0, pick_u16()}, 4);
      end else if (pick < 74) begin
         // A surrogate pair, sometimes one that joins to a noncharacter.
         hi = 16'($urandom_range(16'hD800, 16'hDBFF));
         lo = 16'($urandom_range(16'hDC00, 16'hDFFF));
         if ($urandom_range(0, 2) == 0) begin
            hi[5:0] = 6'h3F;
            lo[9:1] = 9'h1FF;
         end
         queue_str("\\u");
         queue_hex({16'd0, hi}, 4);
         queue_str("\\u");
         queue_hex({16'd0, lo}, 4);
      end else if (pick < 84) begin
         queue_str("\\u{");
         case ($urandom_range(0, 5))
            0: queue_hex($urandom(), 8);
            1: begin
               // Nine digits overflow unless the first one is zero.
               add_byte(hex_char(4'($urandom_range(0, 15))));
               queue_hex($urandom(), 8);
            end
            2: queue_hex(32'($urandom_range(0, 32'h10_FFFF)), $urandom_range(1, 6));
            3: queue_hex(32'h11_0000 + 32'($urandom_range(0, 255)), 6);
            4: ;  // empty braces decode as U+0000
            default: queue_hex(32'($urandom_range(16'hD800, 16'hDFFF)), 4);
         endcase
         add_byte("}");
      end else if (pick < 89) begin
         queue_str("\\x");
         queue_hex(32'($urandom_range(0, 255)), 2);
      end else if (pick < 94) begin
         // Backslash line continuation in all four line-ending forms.
         add_byte(BACKSLASH);
         case ($urandom_range(0, 3))
            0: add_byte(8'h0D);
            1: add_byte(8'h0A);
            2: begin add_byte(8'h0D); add_byte(8'h0A); end
            default: begin add_byte(8'h0A); add_byte(8'h0D); end
         endcase
      end else begin
         // Escapes cut short by a byte that is not a hex digit.
         c = 8'($urandom_range(8'h67, 8'h7A));
         case ($urandom_range(0, 3))
            0: begin
               queue_str("\\u");
               queue_hex($urandom(), $urandom_range(0, 3));
            end
            1: queue_str("\\x");
            2: begin
               queue_str("\\x");
               queue_hex($urandom(), 1);
            end
            default: begin
               queue_str("\\u{");
               queue_hex($urandom(), $urandom_range(0, 3));
            end
         endcase
         add_byte(c);
      end
   endtask

   // One literal: an opening quote, some content, then the matching quote or
   // an end-of-input item in its place. Now and then a stray byte comes
   // before the quote, or a spare end of input follows the literal.
   task automatic send_literal(input int n_tok);
      int         roll;
      logic [7:0] q;
      roll = $urandom_range(0, 99);
      q = (roll < 40 && (!mode || roll < 3)) ? SQUOTE : DQUOTE;
      if (roll >= 95) add_byte(8'($urandom_range(0, 255)));
      add_byte(q);
      repeat (n_tok) queue_token();
      if ($urandom_range(0, 99) < 85) begin
         add_byte(q);
         send_text();
         if ($urandom_range(0, 9) == 0) send_item(REQ_END, 8'($urandom_range(0, 255)));
      end else begin
         send_text();
         send_item(REQ_END, 8'($urandom_range(0, 255)));
      end
   endtask

   // Receiver: short random stall bursts, plus a long hold-off on request
   // that lets the command queue fill and push back on the input.
   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (squeeze_asks != squeeze_done) begin
            squeeze_done++;
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int literals;
      int n_tok;
      literals = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, strict mode. The write itself starts with an end of input
      // while idle, which must give an error.
      write_mode(1'b1);
      send_item(REQ_DATA, 8'h00);     // a non-quote byte while idle
      send_item(REQ_DATA, SQUOTE);    // single quote is not an opener in strict mode
      // The top byte value passes through, the largest code point encodes to
      // four bytes, then a raw control byte kills the literal.
      add_byte(DQUOTE);
      add_byte(8'hFF);
      queue_str("\\u{10FFFF}");
      add_byte(8'h01);
      send_text();

      // Directed, lax mode: single quotes, a CR LF continuation, a hex byte
      // escape, and a lone lead surrogate flushed as U+FFFD when the input
      // ends without a closing quote.
      write_mode(1'b0);
      add_byte(SQUOTE);
      add_byte(BACKSLASH);
      add_byte(8'h0D);
      add_byte(8'h0A);
      queue_str("\\x41\\uD83D");
      send_text();
      send_item(REQ_END, 8'hFF);

      // Random literals, switching the mode every few of them. Two of them run
      // long while the receiver holds off. Idling stops near the end.
      while (sent < RANDOM_ITEMS) begin
         if (literals % 5 == 0) write_mode(~mode);
         if (sent > RANDOM_ITEMS - 30) gaps_on = 1'b0;
         if (literals == 3 || literals == 12) begin
            squeeze_asks <= squeeze_asks + 1;
            n_tok = 24;
         end else if ($urandom_range(0, 9) == 0) begin
            n_tok = 16;
         end else begin
            n_tok = $urandom_range(0, 6);
         end
         send_literal(n_tok);
         literals++;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every item at eight results, each
   // behind the longest stall, plus the two hold-offs.
   initial begin : watchdog
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- json_string_unescape_utf8_core.f -----
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_core.sv
test/unescape_checker.sv
test/tb.sv
